// File: rtl/core/hsl2rgb_pkg.sv
// Package with the fixed-point formats, sector codes and constants of the HSL to RGB converter.
package hsl2rgb_pkg;

  // Field widths of the input and result items.
  localparam int HUE_W  = 15;
  localparam int UNIT_W = 13;
  localparam int CHAN_W = 13;

  // Fixed-point formats.
  localparam int UNIT_FRAC_BITS = 12;
  localparam int HUE_FRAC_BITS  = 6;

  localparam int UNIT_ONE  = 1 << UNIT_FRAC_BITS;
  localparam int SIXTY_DEG = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN = 360 << HUE_FRAC_BITS;

  localparam logic [HUE_W-1:0]  FULL_TURN_H = HUE_W'(FULL_TURN);
  localparam logic [UNIT_W-1:0] UNIT_ONE_U  = UNIT_W'(UNIT_ONE);

  // Signed hue offset within the 120 degree period, and the x weight.
  localparam int W_W = HUE_W + 1;
  localparam logic signed [W_W-1:0] SIXTY_S = W_W'(SIXTY_DEG);

  // Signed width for 2l - 1.0.
  localparam int DL_W = UNIT_W + 2;
  localparam logic signed [DL_W-1:0] UNIT_ONE_S = DL_W'(UNIT_ONE);

  // Chroma scaled by 1.0 squared, and its sums with the scaled lightness.
  localparam int PROD_W = 2 * UNIT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int HALF_SHIFT = UNIT_FRAC_BITS + 1;

  // The common denominator is 15 * 2^XSHIFT: the power of two is a shift,
  // the factor 15 is a multiplication by a rounded-up reciprocal.
  localparam int XPROD_W = PROD_W + 1 + W_W;
  localparam int XSHIFT  = UNIT_FRAC_BITS + HUE_FRAC_BITS + 3;
  localparam int Q_W     = XPROD_W - XSHIFT + 2;
  localparam int RECIP_SHIFT = UNIT_FRAC_BITS + 8;
  localparam int RECIP_W     = RECIP_SHIFT - 3;
  localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15);
  localparam int RPROD_W = Q_W - 1 + RECIP_W;

  // Hue sectors of 60 degrees, named by the colors at their ends.
  typedef enum logic [2:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_e;

endpackage

// File: rtl/core/hsl_to_rgb_converter.sv
// Top level of the pipelined HSL to RGB converter.
//
// Usage: one transaction on the input channel (in_valid_i, in_stall_o) carries a
// hue, saturation and lightness triple; one transaction on the output channel
// (out_valid_o, out_stall_i) carries the red, green and blue channels and the
// in_range flag. Every input transaction gives exactly one output transaction, in order.
// Out-of-range inputs give zero channels with in_range_o low.
// The datapath is five register stages: range check and hue folding, the chroma
// multiply, the x-weight multiply, the shift by the power-of-two part of the
// denominator, and the reciprocal multiply for the factor 15 with the sector mux
// into the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// A stall freezes the run of full stages at the output end; the others still move,
// so in_stall_o rises only when the whole pipeline holds data and out_stall_i is high.
// Reset clears all stage valid bits; the pipeline then starts empty.
module hsl_to_rgb_converter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]    hue_i,
  input  logic [hsl2rgb_pkg::UNIT_W-1:0]   saturation_i,
  input  logic [hsl2rgb_pkg::UNIT_W-1:0]   lightness_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hsl2rgb_pkg::CHAN_W-1:0]   red_o,
  output logic [hsl2rgb_pkg::CHAN_W-1:0]   green_o,
  output logic [hsl2rgb_pkg::CHAN_W-1:0]   blue_o,
  output logic                             in_range_o
);

  typedef struct packed {
    logic                                   ok;
    hsl2rgb_pkg::sector_e                   sector;
    logic [hsl2rgb_pkg::UNIT_W-1:0]         light;
    logic [hsl2rgb_pkg::UNIT_W-1:0]         sat;
    logic [hsl2rgb_pkg::UNIT_W-1:0]         achrom;
    logic signed [hsl2rgb_pkg::W_W-1:0]     weight;
  } st1_t;

  typedef struct packed {
    logic                                   ok;
    hsl2rgb_pkg::sector_e                   sector;
    logic [hsl2rgb_pkg::UNIT_W-1:0]         light;
    logic [hsl2rgb_pkg::PROD_W-1:0]         c2;
    logic signed [hsl2rgb_pkg::W_W-1:0]     weight;
  } st2_t;

  typedef struct packed {
    logic                                   ok;
    hsl2rgb_pkg::sector_e                   sector;
    logic [hsl2rgb_pkg::UNIT_W-1:0]         light;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         cm;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         mm;
    logic signed [hsl2rgb_pkg::XPROD_W-1:0] xprod;
  } st3_t;

  typedef struct packed {
    logic                                   ok;
    hsl2rgb_pkg::sector_e                   sector;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         cm;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         mm;
    logic signed [hsl2rgb_pkg::Q_W-1:0]     q;
  } st4_t;

  typedef struct packed {
    logic                                   ok;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         red;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         green;
    logic [hsl2rgb_pkg::CHAN_W-1:0]         blue;
  } st5_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st4_t s4_d, s4_q;
  st5_t s5_d, s5_q;

  // A stage takes new data when it is empty or its contents move on.
  assign rdy5 = !v5_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // Stage 1: range check, |2l - 1|, hue sector and distance from mid-period.
  logic signed [hsl2rgb_pkg::DL_W-1:0] dl, dl_abs, achrom_s;
  logic [hsl2rgb_pkg::HUE_W-1:0]       hue_p;
  logic signed [hsl2rgb_pkg::W_W-1:0]  dh, dh_abs;
  hsl2rgb_pkg::sector_e                sector;

  always_comb begin
    if (hue_i < hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::SIXTY_DEG)) begin
      sector = hsl2rgb_pkg::SECT_R_Y;
    end else if (hue_i < hsl2rgb_pkg::HUE_W'(2 * hsl2rgb_pkg::SIXTY_DEG)) begin
      sector = hsl2rgb_pkg::SECT_Y_G;
    end else if (hue_i < hsl2rgb_pkg::HUE_W'(3 * hsl2rgb_pkg::SIXTY_DEG)) begin
      sector = hsl2rgb_pkg::SECT_G_C;
    end else if (hue_i < hsl2rgb_pkg::HUE_W'(4 * hsl2rgb_pkg::SIXTY_DEG)) begin
      sector = hsl2rgb_pkg::SECT_C_B;
    end else if (hue_i < hsl2rgb_pkg::HUE_W'(5 * hsl2rgb_pkg::SIXTY_DEG)) begin
      sector = hsl2rgb_pkg::SECT_B_M;
    end else begin
      sector = hsl2rgb_pkg::SECT_M_R;
    end

    case (sector)
      hsl2rgb_pkg::SECT_R_Y, hsl2rgb_pkg::SECT_Y_G: begin
        hue_p = hue_i;
      end
      hsl2rgb_pkg::SECT_G_C, hsl2rgb_pkg::SECT_C_B: begin
        hue_p = hue_i - hsl2rgb_pkg::HUE_W'(2 * hsl2rgb_pkg::SIXTY_DEG);
      end
      default: begin
        hue_p = hue_i - hsl2rgb_pkg::HUE_W'(4 * hsl2rgb_pkg::SIXTY_DEG);
      end
    endcase

    dh       = $signed({1'b0, hue_p}) - hsl2rgb_pkg::SIXTY_S;
    dh_abs   = (dh < 0) ? -dh : dh;
    dl       = $signed({1'b0, lightness_i, 1'b0}) - hsl2rgb_pkg::UNIT_ONE_S;
    dl_abs   = (dl < 0) ? -dl : dl;
    achrom_s = hsl2rgb_pkg::UNIT_ONE_S - dl_abs;

    s1_d.ok     = (hue_i <= hsl2rgb_pkg::FULL_TURN_H) &&
                  (saturation_i <= hsl2rgb_pkg::UNIT_ONE_U) &&
                  (lightness_i <= hsl2rgb_pkg::UNIT_ONE_U);
    s1_d.sector = sector;
    s1_d.light  = lightness_i;
    s1_d.sat    = saturation_i;
    s1_d.achrom = achrom_s[hsl2rgb_pkg::UNIT_W-1:0];
    s1_d.weight = hsl2rgb_pkg::SIXTY_S - (dh_abs <<< 1);
  end

  // Stage 2: chroma scaled by 1.0 squared.
  always_comb begin
    s2_d.ok     = s1_q.ok;
    s2_d.sector = s1_q.sector;
    s2_d.light  = s1_q.light;
    s2_d.c2     = hsl2rgb_pkg::PROD_W'(s1_q.achrom) * hsl2rgb_pkg::PROD_W'(s1_q.sat);
    s2_d.weight = s1_q.weight;
  end

  // Stage 3: c + m and m by a shift, and the x term product.
  logic signed [hsl2rgb_pkg::SUM_W-1:0] l_sh, cm_num, mm_num;

  always_comb begin
    l_sh   = $signed(hsl2rgb_pkg::SUM_W'(s2_q.light) << hsl2rgb_pkg::HALF_SHIFT);
    cm_num = l_sh + $signed(hsl2rgb_pkg::SUM_W'(s2_q.c2));
    mm_num = l_sh - $signed(hsl2rgb_pkg::SUM_W'(s2_q.c2));

    s3_d.ok     = s2_q.ok;
    s3_d.sector = s2_q.sector;
    s3_d.light  = s2_q.light;
    s3_d.cm     = hsl2rgb_pkg::CHAN_W'(cm_num >>> hsl2rgb_pkg::HALF_SHIFT);
    s3_d.mm     = (mm_num <= 0) ? '0 : hsl2rgb_pkg::CHAN_W'(mm_num >>> hsl2rgb_pkg::HALF_SHIFT);
    s3_d.xprod  = hsl2rgb_pkg::XPROD_W'($signed({1'b0, s2_q.c2})) *
                  hsl2rgb_pkg::XPROD_W'(s2_q.weight);
  end

  // Stage 4: x + m numerator over the power-of-two part of the denominator.
  always_comb begin
    s4_d.ok     = s3_q.ok;
    s4_d.sector = s3_q.sector;
    s4_d.cm     = s3_q.cm;
    s4_d.mm     = s3_q.mm;
    s4_d.q      = $signed(hsl2rgb_pkg::Q_W'(s3_q.light) * hsl2rgb_pkg::Q_W'(15)) +
                  $signed(hsl2rgb_pkg::Q_W'(s3_q.xprod >>> hsl2rgb_pkg::XSHIFT));
  end

  // Stage 5: division by 15 through the reciprocal, then the sector mux.
  logic [hsl2rgb_pkg::RPROD_W-1:0] rprod;
  logic [hsl2rgb_pkg::CHAN_W-1:0]  xm;

  always_comb begin
    rprod = hsl2rgb_pkg::RPROD_W'(s4_q.q[hsl2rgb_pkg::Q_W-2:0]) *
            hsl2rgb_pkg::RPROD_W'(hsl2rgb_pkg::RECIP15);
    xm    = (s4_q.q <= 0) ? '0 : hsl2rgb_pkg::CHAN_W'(rprod >> hsl2rgb_pkg::RECIP_SHIFT);

    s5_d.ok = s4_q.ok;
    case (s4_q.sector)
      hsl2rgb_pkg::SECT_R_Y: begin
        s5_d.red = s4_q.cm; s5_d.green = xm;      s5_d.blue = s4_q.mm;
      end
      hsl2rgb_pkg::SECT_Y_G: begin
        s5_d.red = xm;      s5_d.green = s4_q.cm; s5_d.blue = s4_q.mm;
      end
      hsl2rgb_pkg::SECT_G_C: begin
        s5_d.red = s4_q.mm; s5_d.green = s4_q.cm; s5_d.blue = xm;
      end
      hsl2rgb_pkg::SECT_C_B: begin
        s5_d.red = s4_q.mm; s5_d.green = xm;      s5_d.blue = s4_q.cm;
      end
      hsl2rgb_pkg::SECT_B_M: begin
        s5_d.red = xm;      s5_d.green = s4_q.mm; s5_d.blue = s4_q.cm;
      end
      default: begin
        s5_d.red = s4_q.cm; s5_d.green = s4_q.mm; s5_d.blue = xm;
      end
    endcase

    if (!s4_q.ok) begin
      s5_d.red   = '0;
      s5_d.green = '0;
      s5_d.blue  = '0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
    if (rdy5 && v4_q)       s5_q <= s5_d;
  end

  assign out_valid_o = v5_q;
  assign red_o       = s5_q.red;
  assign green_o     = s5_q.green;
  assign blue_o      = s5_q.blue;
  assign in_range_o  = s5_q.ok;

  // An out-of-range transaction carries zero channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("out-of-range result with nonzero channel");

  // No channel of an in-range result exceeds full intensity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_range_o) |->
      (red_o <= hsl2rgb_pkg::UNIT_ONE_U && green_o <= hsl2rgb_pkg::UNIT_ONE_U &&
       blue_o <= hsl2rgb_pkg::UNIT_ONE_U))
    else $error("channel above full intensity");

  // The input side stalls only when the pipeline is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with room in the pipeline");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the HSL to RGB converter with stalls on both channels.
module testbench;

  typedef struct packed {
    logic [hsl2rgb_pkg::CHAN_W-1:0] red;
    logic [hsl2rgb_pkg::CHAN_W-1:0] green;
    logic [hsl2rgb_pkg::CHAN_W-1:0] blue;
    logic                           in_range;
  } rgb_t;

  localparam logic [hsl2rgb_pkg::UNIT_W-1:0] HALF_U =
    hsl2rgb_pkg::UNIT_W'(hsl2rgb_pkg::UNIT_ONE / 2);

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [hsl2rgb_pkg::HUE_W-1:0]  hue_i = '0;
  logic [hsl2rgb_pkg::UNIT_W-1:0] saturation_i = '0;
  logic [hsl2rgb_pkg::UNIT_W-1:0] lightness_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [hsl2rgb_pkg::CHAN_W-1:0] red_o;
  logic [hsl2rgb_pkg::CHAN_W-1:0] green_o;
  logic [hsl2rgb_pkg::CHAN_W-1:0] blue_o;
  logic                           in_range_o;

  rgb_t rgb_expected[$];
  int   fail_count = 0;

  // Receiver behavior, set by the test tasks.
  int stall_pct = 0;
  int hold_len = 0;

  hsl_to_rgb_converter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .in_range_o   (in_range_o)
  );

  always #2 clk_i = ~clk_i;

  // Truncated channel value; all terms share one denominator.
  function automatic logic [hsl2rgb_pkg::CHAN_W-1:0] channel_floor(input longint num,
                                                                   input longint denom);
    if (num <= 0) begin
      return '0;
    end
    return hsl2rgb_pkg::CHAN_W'(num / denom);
  endfunction

  function automatic rgb_t predict_rgb(input logic [hsl2rgb_pkg::HUE_W-1:0] h,
                                       input logic [hsl2rgb_pkg::UNIT_W-1:0] s,
                                       input logic [hsl2rgb_pkg::UNIT_W-1:0] l);
    longint               hv, sv, lv, lev_dev, chroma_sq, off, denom, hi, lo, mid;
    hsl2rgb_pkg::sector_e sect;
    rgb_t                 res;
    hv = h;
    sv = s;
    lv = l;
    res = '0;
    if (hv > hsl2rgb_pkg::FULL_TURN || sv > hsl2rgb_pkg::UNIT_ONE ||
        lv > hsl2rgb_pkg::UNIT_ONE) begin
      return res;
    end
    lev_dev = 2 * lv - hsl2rgb_pkg::UNIT_ONE;
    if (lev_dev < 0) begin
      lev_dev = -lev_dev;
    end
    chroma_sq = (hsl2rgb_pkg::UNIT_ONE - lev_dev) * sv;
    off = (hv % (2 * hsl2rgb_pkg::SIXTY_DEG)) - hsl2rgb_pkg::SIXTY_DEG;
    if (off < 0) begin
      off = -off;
    end
    denom = 2 * hsl2rgb_pkg::UNIT_ONE * hsl2rgb_pkg::SIXTY_DEG;
    hi = lv * denom + chroma_sq * hsl2rgb_pkg::SIXTY_DEG;
    lo = lv * denom - chroma_sq * hsl2rgb_pkg::SIXTY_DEG;
    mid = lo + 2 * chroma_sq * (hsl2rgb_pkg::SIXTY_DEG - off);
    // A hue of exactly 360 degrees stays in the last sector.
    if (hv >= 5 * hsl2rgb_pkg::SIXTY_DEG) begin
      sect = hsl2rgb_pkg::SECT_M_R;
    end else begin
      sect = hsl2rgb_pkg::sector_e'(3'(hv / hsl2rgb_pkg::SIXTY_DEG));
    end
    case (sect)
      hsl2rgb_pkg::SECT_R_Y: begin
        res.red = channel_floor(hi, denom); res.green = channel_floor(mid, denom);
        res.blue = channel_floor(lo, denom);
      end
      hsl2rgb_pkg::SECT_Y_G: begin
        res.red = channel_floor(mid, denom); res.green = channel_floor(hi, denom);
        res.blue = channel_floor(lo, denom);
      end
      hsl2rgb_pkg::SECT_G_C: begin
        res.red = channel_floor(lo, denom); res.green = channel_floor(hi, denom);
        res.blue = channel_floor(mid, denom);
      end
      hsl2rgb_pkg::SECT_C_B: begin
        res.red = channel_floor(lo, denom); res.green = channel_floor(mid, denom);
        res.blue = channel_floor(hi, denom);
      end
      hsl2rgb_pkg::SECT_B_M: begin
        res.red = channel_floor(mid, denom); res.green = channel_floor(lo, denom);
        res.blue = channel_floor(hi, denom);
      end
      default: begin
        res.red = channel_floor(hi, denom); res.green = channel_floor(lo, denom);
        res.blue = channel_floor(mid, denom);
      end
    endcase
    res.in_range = 1'b1;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_triple(input logic [hsl2rgb_pkg::HUE_W-1:0] h,
                             input logic [hsl2rgb_pkg::UNIT_W-1:0] s,
                             input logic [hsl2rgb_pkg::UNIT_W-1:0] l);
    in_valid_i   <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    lightness_i  <= l;
    do @(posedge clk_i); while (in_stall_o);
    rgb_expected.push_back(predict_rgb(h, s, l));
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i   <= 1'b0;
    hue_i        <= hsl2rgb_pkg::HUE_W'($urandom);
    saturation_i <= hsl2rgb_pkg::UNIT_W'($urandom);
    lightness_i  <= hsl2rgb_pkg::UNIT_W'($urandom);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Mostly in-range triples, some near sector edges and extremes, some out of range.
  task automatic random_triple(output logic [hsl2rgb_pkg::HUE_W-1:0] h,
                               output logic [hsl2rgb_pkg::UNIT_W-1:0] s,
                               output logic [hsl2rgb_pkg::UNIT_W-1:0] l);
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      h = hsl2rgb_pkg::HUE_W'($urandom);
      s = hsl2rgb_pkg::UNIT_W'($urandom);
      l = hsl2rgb_pkg::UNIT_W'($urandom);
    end else if (pick < 30) begin
      h = hsl2rgb_pkg::HUE_W'($urandom_range(6) * hsl2rgb_pkg::SIXTY_DEG +
                              $urandom_range(2)) - 1'b1;
      if (h > hsl2rgb_pkg::FULL_TURN_H) begin
        h = hsl2rgb_pkg::FULL_TURN_H;
      end
      s = ($urandom_range(1) != 0) ? hsl2rgb_pkg::UNIT_ONE_U
                                   : hsl2rgb_pkg::UNIT_W'($urandom_range(hsl2rgb_pkg::UNIT_ONE));
      l = ($urandom_range(1) != 0) ?
          hsl2rgb_pkg::UNIT_W'($urandom_range(1) * hsl2rgb_pkg::UNIT_ONE) :
          hsl2rgb_pkg::UNIT_W'($urandom_range(hsl2rgb_pkg::UNIT_ONE));
    end else begin
      h = hsl2rgb_pkg::HUE_W'($urandom_range(hsl2rgb_pkg::FULL_TURN));
      s = hsl2rgb_pkg::UNIT_W'($urandom_range(hsl2rgb_pkg::UNIT_ONE));
      l = hsl2rgb_pkg::UNIT_W'($urandom_range(hsl2rgb_pkg::UNIT_ONE));
    end
  endtask

  task automatic run_random(input int count, input int burst_max, input int gap_max);
    logic [hsl2rgb_pkg::HUE_W-1:0]  h;
    logic [hsl2rgb_pkg::UNIT_W-1:0] s, l;
    int                             burst, gap;
    while (count > 0) begin
      burst = $urandom_range(1, burst_max);
      while (burst > 0 && count > 0) begin
        random_triple(h, s, l);
        send_triple(h, s, l);
        burst--;
        count--;
      end
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        idle_sender(gap);
      end
    end
  endtask

  task automatic test_directed();
    stall_pct = 0;
    send_triple('0, '0, '0);
    send_triple('0, hsl2rgb_pkg::UNIT_ONE_U, HALF_U);
    send_triple(hsl2rgb_pkg::FULL_TURN_H, hsl2rgb_pkg::UNIT_ONE_U, HALF_U);
    send_triple(hsl2rgb_pkg::FULL_TURN_H + 1'b1, hsl2rgb_pkg::UNIT_ONE_U, HALF_U);
    send_triple('0, hsl2rgb_pkg::UNIT_ONE_U + 1'b1, HALF_U);
    send_triple('0, HALF_U, hsl2rgb_pkg::UNIT_ONE_U + 1'b1);
    send_triple('1, '1, '1);
    for (int k = 1; k < 6; k++) begin
      send_triple(hsl2rgb_pkg::HUE_W'(k * hsl2rgb_pkg::SIXTY_DEG), hsl2rgb_pkg::UNIT_ONE_U,
                  HALF_U);
      send_triple(hsl2rgb_pkg::HUE_W'(k * hsl2rgb_pkg::SIXTY_DEG - 1),
                  hsl2rgb_pkg::UNIT_ONE_U, HALF_U);
    end
    send_triple(hsl2rgb_pkg::HUE_W'(12345), hsl2rgb_pkg::UNIT_ONE_U, hsl2rgb_pkg::UNIT_ONE_U);
    send_triple(hsl2rgb_pkg::HUE_W'(12345), hsl2rgb_pkg::UNIT_ONE_U, '0);
    send_triple(hsl2rgb_pkg::HUE_W'(9000), hsl2rgb_pkg::UNIT_W'(1234),
                hsl2rgb_pkg::UNIT_W'(3000));
    send_triple(hsl2rgb_pkg::HUE_W'(1920), hsl2rgb_pkg::UNIT_ONE_U,
                hsl2rgb_pkg::UNIT_W'(1024));
    send_triple(hsl2rgb_pkg::HUE_W'(21000), '0, hsl2rgb_pkg::UNIT_ONE_U);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    stall_pct = 0;
    run_random(300, 300, 0);
    wait_drained();
  endtask

  task automatic test_bursts_and_stalls();
    stall_pct = 30;
    run_random(900, 20, 6);
    wait_drained();
  endtask

  task automatic test_heavy_stall();
    stall_pct = 70;
    run_random(350, 12, 3);
    wait_drained();
  endtask

  // A long hold-off on the output fills the pipeline so the input must stall.
  task automatic test_pipeline_full();
    stall_pct = 20;
    @(posedge clk_i);
    hold_len = 200;
    @(negedge clk_i);
    run_random(300, 300, 0);
    wait_drained();
  endtask

  always @(negedge clk_i) begin : receiver_stall
    int hold_left;
    int run_left;
    bit stall_run;
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (run_left <= 0) begin
        stall_run = ($urandom_range(99) < stall_pct);
        run_left = $urandom_range(1, 8);
      end
      out_stall_i <= stall_run;
      run_left--;
    end
  end

  always @(posedge clk_i) begin : check_rgb
    rgb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected transaction: red %0d green %0d blue %0d in_range %0b",
               red_o, green_o, blue_o, in_range_o);
        fail_count++;
      end else begin
        want = rgb_expected.pop_front();
        if (red_o !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, red_o);
          fail_count++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, green_o);
          fail_count++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, blue_o);
          fail_count++;
        end
        if (in_range_o !== want.in_range) begin
          $error("in_range: expected %0b, actual %0b", want.in_range, in_range_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_back_to_back();
    test_bursts_and_stalls();
    test_heavy_stall();
    test_pipeline_full();
    stall_pct = 0;
    wait_drained();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
